/* sv/cllb_pkg.sv */
`default_nettype none
package cllb_pkg;

  // Grid and capacity
  localparam int GRID_SIDE     = 16;
  localparam int MAX_PARTICLES = 65536;
  localparam int NUM_CELLS     = GRID_SIDE * GRID_SIDE * GRID_SIDE;

  // Derived widths
  localparam int SIDE_W = $clog2(GRID_SIDE);
  localparam int CELL_W = $clog2(NUM_CELLS);

  // Fixed field widths
  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 31;
  localparam int QUERY_W    = 12;
  localparam int HEAD_W     = 16;
  localparam int COUNT_W    = 17;
  localparam int CFG_DATA_W = 32;

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = COORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_X_ORIGIN  = 2'd0,
    CFG_Y_ORIGIN  = 2'd1,
    CFG_Z_ORIGIN  = 2'd2,
    CFG_CELL_SIZE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic signed [COORD_W-1:0]  z_coord;
    logic        [QUERY_W-1:0]  query_cell;
  } req_item_t;

  typedef struct packed {
    logic [HEAD_W-1:0]  particle_index;
    logic [HEAD_W-1:0]  next_in_cell;
    logic [QUERY_W-1:0] cell_number;
    logic [HEAD_W-1:0]  head_value;
    logic               full_flag;
  } rsp_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic read_head;
    logic sweep;
    logic load_out;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic div_busy;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/cllb_divider.sv */
`default_nettype none
module cllb_divider (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [cllb_pkg::COORD_W-1:0]   coord,
  input  wire logic signed [cllb_pkg::COORD_W-1:0]   origin,
  input  wire logic        [cllb_pkg::SIZE_W-1:0]    divisor,
  output logic                                       busy,
  output logic             [cllb_pkg::SIDE_W-1:0]    index
);
  import cllb_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [COORD_W-1:0]   quo;
  logic [COORD_W-1:0]   rem;
  logic [SIZE_W-1:0]    dvs;
  logic                 neg;

  logic [COORD_W:0]     diff;
  logic [COORD_W-1:0]   shifted;
  logic                 fits;

  // Exact 33-bit difference; top bit marks below origin
  assign diff = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};

  // One restoring step: shift in next dividend bit, try the subtract
  assign shifted = {rem[COORD_W-2:0], quo[COORD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  assign busy = cnt != '0;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  // Dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= diff[COORD_W-1:0];
      rem <= '0;
      neg <= diff[COORD_W];
      dvs <= (divisor == '0) ? SIZE_W'(1) : divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[COORD_W-2:0], fits};
    end
  end

  // Clamp to the grid
  always_comb begin
    if (neg) begin
      index = '0;
    end else if (quo > COORD_W'(GRID_SIDE - 1)) begin
      index = SIDE_W'(GRID_SIDE - 1);
    end else begin
      index = SIDE_W'(quo);
    end
  end

endmodule
`default_nettype wire

/* sv/cllb_datapath.sv */
`default_nettype none
module cllb_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire cllb_pkg::dp_ctrl_t                    ctrl,
  output cllb_pkg::dp_status_t                       status,
  input  wire cllb_pkg::req_item_t                   req_data,
  output logic                                       rsp_valid,
  input  wire logic                                  rsp_ready,
  output cllb_pkg::rsp_item_t                        rsp_data,
  input  wire logic                                  cfg_valid,
  input  wire cllb_pkg::cfg_idx_t                    cfg_index,
  input  wire logic        [cllb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cllb_pkg::*;

  logic signed [COORD_W-1:0] x_origin;
  logic signed [COORD_W-1:0] y_origin;
  logic signed [COORD_W-1:0] z_origin;
  logic        [SIZE_W-1:0]  cell_size;

  req_item_t           req;
  logic [COUNT_W-1:0]  count;
  logic [CELL_W-1:0]   sweep_addr;
  logic [CELL_W-1:0]   cell_num;
  logic [HEAD_W-1:0]   rd_data;
  logic [HEAD_W-1:0]   cell_heads [NUM_CELLS];

  logic                div_start;
  logic [2:0]          busy;
  logic [SIDE_W-1:0]   gx, gy, gz;
  logic [CELL_W-1:0]   cell_comb;
  logic [CELL_W-1:0]   rd_addr;
  logic                in_range;
  logic                full;
  logic                do_insert;
  logic                we;
  logic [CELL_W-1:0]   wr_addr;
  logic [HEAD_W-1:0]   wr_data;
  logic                sweep_last;
  rsp_item_t           rsp_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin  <= '0;
      y_origin  <= '0;
      z_origin  <= '0;
      cell_size <= SIZE_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_X_ORIGIN:  x_origin  <= cfg_data;
        CFG_Y_ORIGIN:  y_origin  <= cfg_data;
        CFG_Z_ORIGIN:  z_origin  <= cfg_data;
        CFG_CELL_SIZE: cell_size <= cfg_data[SIZE_W-1:0];
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req <= req_data;
    end
  end

  assign div_start = ctrl.capture && (req_data.command == CMD_INSERT);

  cllb_divider u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .coord(req_data.x_coord),
    .origin(x_origin), .divisor(cell_size), .busy(busy[0]), .index(gx)
  );
  cllb_divider u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .coord(req_data.y_coord),
    .origin(y_origin), .divisor(cell_size), .busy(busy[1]), .index(gy)
  );
  cllb_divider u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .coord(req_data.z_coord),
    .origin(z_origin), .divisor(cell_size), .busy(busy[2]), .index(gz)
  );

  // Cell number from the clamped axis indices
  assign cell_comb = (CELL_W'(gx) * CELL_W'(GRID_SIDE) + CELL_W'(gy)) * CELL_W'(GRID_SIDE)
                     + CELL_W'(gz);

  assign in_range = 32'(req.query_cell) < 32'(NUM_CELLS);
  assign rd_addr  = (req.command == CMD_READ) ? CELL_W'(req.query_cell) : cell_comb;

  // Latch the cell and read its head
  always_ff @(posedge clk) begin
    if (ctrl.read_head) begin
      cell_num <= cell_comb;
      rd_data  <= cell_heads[rd_addr];
    end
  end

  // Head table write port: sweep or new head
  assign full      = 32'(count) >= 32'(MAX_PARTICLES);
  assign do_insert = ctrl.load_out && (req.command == CMD_INSERT) && !full;
  assign we        = ctrl.sweep || do_insert;
  assign wr_addr   = ctrl.sweep ? sweep_addr : cell_num;
  assign wr_data   = ctrl.sweep ? '0 : count[HEAD_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      cell_heads[wr_addr] <= wr_data;
    end
  end

  // Sweep address walks the whole table
  assign sweep_last = sweep_addr == CELL_W'(NUM_CELLS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (ctrl.sweep) begin
      sweep_addr <= sweep_last ? '0 : sweep_addr + CELL_W'(1);
    end
  end

  // Particle counter
  always_ff @(posedge clk) begin
    if (rst || ctrl.sweep) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + COUNT_W'(1);
    end
  end

  // Form the result
  always_comb begin
    rsp_next = '0;
    unique case (req.command)
      CMD_INSERT: begin
        rsp_next.cell_number = QUERY_W'(cell_num);
        if (full) begin
          rsp_next.full_flag = 1'b1;
        end else begin
          rsp_next.particle_index = count[HEAD_W-1:0];
          rsp_next.next_in_cell   = rd_data;
        end
      end
      CMD_READ: begin
        rsp_next.cell_number = req.query_cell;
        rsp_next.head_value  = in_range ? rd_data : '0;
      end
      CMD_CLEAR, CMD_NOP: begin
        rsp_next = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      rsp_data <= rsp_next;
    end
  end

  assign status.div_busy   = |busy;
  assign status.sweep_last = sweep_last;
  assign status.out_free   = !rsp_valid || rsp_ready;

endmodule
`default_nettype wire

/* sv/cllb_controller.sv */
`default_nettype none
module cllb_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  input  wire cllb_pkg::cmd_t        req_command,
  output logic                       req_ready,
  input  wire cllb_pkg::dp_status_t  status,
  output cllb_pkg::dp_ctrl_t         ctrl
);
  import cllb_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_ADDR  = 6'b001000,
    S_DONE  = 6'b010000,
    S_SWEEP = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one request at a time
  always_comb begin
    state_next = state;
    ctrl       = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_INIT: begin
        ctrl.sweep = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.capture = 1'b1;
          unique case (req_command)
            CMD_INSERT: state_next = S_DIV;
            CMD_READ:   state_next = S_ADDR;
            CMD_CLEAR:  state_next = S_SWEEP;
            CMD_NOP:    state_next = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (!status.div_busy) state_next = S_ADDR;
      end
      S_ADDR: begin
        ctrl.read_head = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SWEEP: begin
        ctrl.sweep = 1'b1;
        if (status.sweep_last) state_next = S_DONE;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

/* sv/cell_linked_list_builder.sv */
`default_nettype none
// Linked cell list builder over a cubic grid of GRID_SIDE^3 cells.
// Request channel (req_valid/req_ready/req_data): insert a particle, read one
// cell head, or clear the table and counter. Every request yields exactly one
// response on rsp_valid/rsp_ready/rsp_data, in request order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while no request is in flight.
// Insert: three 32-step restoring dividers (one quotient bit per cycle per axis),
// then one idle check, one head-table read and the output load with the head
// write. Read: one head-table read, then the output load. Clear: one table
// entry zeroed per cycle on the single write port, then the output load.
// One request is processed at a time; req_ready is high only while idle.
// Reset runs a clearing pass over all NUM_CELLS entries (4096 at the default
// grid) with req_ready low; configuration writes are still taken.
// A response waits in the output register while rsp_ready is low; the next
// request is still accepted and processed, and its result is held back until
// the output register is free.
module cell_linked_list_builder (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  req_valid,
  output logic                                       req_ready,
  input  wire cllb_pkg::req_item_t                   req_data,
  output logic                                       rsp_valid,
  input  wire logic                                  rsp_ready,
  output cllb_pkg::rsp_item_t                        rsp_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire cllb_pkg::cfg_idx_t                    cfg_index,
  input  wire logic        [cllb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cllb_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  cllb_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req_data.command),
    .req_ready   (req_ready),
    .status      (status),
    .ctrl        (ctrl)
  );

  cllb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

/* sim/tb_cell_linked_list_builder.sv */
`timescale 1ns / 100ps

module tb_cell_linked_list_builder;
  import cllb_pkg::*;

  localparam int STALL_CYCLES   = 400;
  localparam int PHASE_REQUESTS = 370;
  localparam int DRAIN_CYCLES   = 48;

  typedef struct packed {
    req_item_t req;
    logic      typed;
    rsp_item_t rsp;
  } probe_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req_data = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = CFG_X_ORIGIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the grid registers and the head table
  logic signed [COORD_W-1:0] org_x = '0;
  logic signed [COORD_W-1:0] org_y = '0;
  logic signed [COORD_W-1:0] org_z = '0;
  logic [SIZE_W-1:0]         cell_w = SIZE_W'(65536);
  logic [HEAD_W-1:0]         head_tab [NUM_CELLS];
  int unsigned               part_count = 0;

  rsp_item_t   awaited_replies [$];
  rsp_item_t   want_rsp;
  probe_row_t  probe_tab [$];
  int unsigned bad_replies = 0;
  int unsigned req_idle_pct = 20;
  int unsigned rsp_idle_pct = 73;
  int unsigned hold_requests = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;
  logic [QUERY_W-1:0] last_cell = '0;

  cell_linked_list_builder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor-divide one axis offset into a clamped grid index
  function automatic int grid_axis(logic signed [COORD_W-1:0] c,
                                   logic signed [COORD_W-1:0] o);
    longint diff;
    longint w;
    longint q;
    diff = longint'(c) - longint'(o);
    w = (cell_w == '0) ? 64'sd1 : longint'(cell_w);
    if (diff < 0) return 0;
    q = diff / w;
    if (q > GRID_SIDE - 1) q = GRID_SIDE - 1;
    return int'(q);
  endfunction

  // Apply one command to the shadow list and return the reply it gives
  function automatic rsp_item_t update_cell_list(req_item_t r);
    rsp_item_t o;
    int        c;
    o = '0;
    case (r.command)
      CMD_INSERT: begin
        c = (grid_axis(r.x_coord, org_x) * GRID_SIDE + grid_axis(r.y_coord, org_y))
            * GRID_SIDE + grid_axis(r.z_coord, org_z);
        o.cell_number = QUERY_W'(c);
        if (part_count >= MAX_PARTICLES) begin
          o.full_flag = 1'b1;
        end else begin
          o.particle_index = HEAD_W'(part_count);
          o.next_in_cell   = head_tab[c];
          head_tab[c]      = HEAD_W'(part_count);
          part_count       = (part_count + 1) & 32'h1_FFFF;
        end
      end
      CMD_READ: begin
        o.cell_number = r.query_cell;
        if (r.query_cell < NUM_CELLS) o.head_value = head_tab[r.query_cell];
      end
      CMD_CLEAR: begin
        foreach (head_tab[i]) head_tab[i] = '0;
        part_count = 0;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Place a coordinate in or near the grid, now and then below it or anywhere
  function automatic logic [COORD_W-1:0] near_origin(logic signed [COORD_W-1:0] o);
    longint w;
    longint frac;
    w = (cell_w == '0) ? 64'sd1 : longint'(cell_w);
    case ($urandom_range(7))
      0: return $urandom;
      1: return COORD_W'(longint'(o) - longint'($urandom_range(1, 4096)));
      default: begin
        case ($urandom_range(2))
          0: frac = 0;
          1: frac = w - 1;
          default: frac = longint'($urandom) % w;
        endcase
        return COORD_W'(longint'(o) + longint'($urandom_range(0, GRID_SIDE)) * w + frac);
      end
    endcase
  endfunction

  function automatic req_item_t random_request();
    req_item_t   r;
    int unsigned pick;
    r = '0;
    r.x_coord    = near_origin(org_x);
    r.y_coord    = near_origin(org_y);
    r.z_coord    = near_origin(org_z);
    r.query_cell = $urandom_range(1) ? last_cell : QUERY_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 76) r.command = CMD_INSERT;
    else if (pick < 94) r.command = CMD_READ;
    else if (pick < 98) r.command = CMD_NOP;
    else r.command = CMD_CLEAR;
    return r;
  endfunction

  function automatic probe_row_t probe(cmd_t cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                       logic [COORD_W-1:0] z, logic [QUERY_W-1:0] q,
                                       logic typed, logic [HEAD_W-1:0] idx,
                                       logic [HEAD_W-1:0] nxt, logic [QUERY_W-1:0] cnum,
                                       logic [HEAD_W-1:0] head, logic full);
    probe_row_t row;
    row.req.command        = cmd;
    row.req.x_coord        = x;
    row.req.y_coord        = y;
    row.req.z_coord        = z;
    row.req.query_cell     = q;
    row.typed              = typed;
    row.rsp.particle_index = idx;
    row.rsp.next_in_cell   = nxt;
    row.rsp.cell_number    = cnum;
    row.rsp.head_value     = head;
    row.rsp.full_flag      = full;
    return row;
  endfunction

  // Append one row to the directed table
  task automatic add_probe(probe_row_t row);
    probe_tab = {probe_tab, row};
  endtask

  task automatic log_failure(string what, rsp_item_t want, rsp_item_t got);
    bad_replies++;
    if (bad_replies <= 10)
      $display("%0t %s: expected idx=%h next=%h cell=%h head=%h full=%b",
               $realtime, what, want.particle_index, want.next_in_cell, want.cell_number,
               want.head_value, want.full_flag);
    if (bad_replies <= 10)
      $display("%0t %s: actual   idx=%h next=%h cell=%h head=%h full=%b",
               $realtime, what, got.particle_index, got.next_in_cell, got.cell_number,
               got.head_value, got.full_flag);
  endtask

  // Offer one request, hold it until taken, then predict its reply
  task automatic send_request(req_item_t r, logic typed, rsp_item_t typed_rsp);
    rsp_item_t pred;
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    pred = update_cell_list(r);
    if (typed) pred = typed_rsp;
    awaited_replies = {awaited_replies, pred};
    if (r.command == CMD_INSERT) last_cell = pred.cell_number;
  endtask

  task automatic drain_replies();
    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_ORIGIN:  org_x  = value;
      CFG_Y_ORIGIN:  org_y  = value;
      CFG_Z_ORIGIN:  org_z  = value;
      CFG_CELL_SIZE: cell_w = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_grid(logic [CFG_DATA_W-1:0] x, logic [CFG_DATA_W-1:0] y,
                           logic [CFG_DATA_W-1:0] z, logic [CFG_DATA_W-1:0] size);
    write_register(CFG_X_ORIGIN, x);
    write_register(CFG_Y_ORIGIN, y);
    write_register(CFG_Z_ORIGIN, z);
    write_register(CFG_CELL_SIZE, size);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random back-pressure, plus a long hold when asked
  always @(posedge clk) begin
    if (holds_taken != hold_requests) begin
      holds_taken <= hold_requests;
      hold_left   <= STALL_CYCLES;
      rsp_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Check each reply against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_replies.size() == 0) begin
        log_failure("reply with nothing outstanding", '0, rsp_data);
      end else begin
        want_rsp = awaited_replies.pop_front();
        if (want_rsp.particle_index !== rsp_data.particle_index ||
            want_rsp.next_in_cell   !== rsp_data.next_in_cell   ||
            want_rsp.cell_number    !== rsp_data.cell_number    ||
            want_rsp.head_value     !== rsp_data.head_value     ||
            want_rsp.full_flag      !== rsp_data.full_flag)
          log_failure("reply mismatch", want_rsp, rsp_data);
      end
    end
  end

  initial begin
    #120_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    req_item_t r;
    foreach (head_tab[i]) head_tab[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table at reset settings: origin zero, 65536 units per cell
    add_probe(probe(CMD_READ, 0, 0, 0, 12'd0, 1, 0, 0, 12'd0, 0, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'hFFF, 1, 0, 0, 12'hFFF, 0, 0));
    add_probe(probe(CMD_NOP, '1, '1, '1, '1, 1, 0, 0, 0, 0, 0));
    add_probe(probe(CMD_INSERT, 0, 0, 0, 0, 1, 0, 0, 12'd0, 0, 0));
    add_probe(probe(CMD_INSERT, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 0,
                    1, 1, 0, 12'd0, 0, 0));
    add_probe(probe(CMD_INSERT, 0, 0, 0, 0, 1, 2, 1, 12'd0, 0, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'd0, 1, 0, 0, 12'd0, 2, 0));
    add_probe(probe(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                    1, 3, 0, 12'd4095, 0, 0));
    add_probe(probe(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                    1, 4, 2, 12'd0, 0, 0));
    add_probe(probe(CMD_INSERT, 32'h0001_8000, 32'h0002_8000, 32'h000F_FFFF, 0,
                    1, 5, 0, 12'd303, 0, 0));
    add_probe(probe(CMD_INSERT, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0001_0000, 0,
                    1, 6, 0, 12'd3841, 0, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'd303, 1, 0, 0, 12'd303, 5, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'd4095, 1, 0, 0, 12'd4095, 3, 0));
    add_probe(probe(CMD_INSERT, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000, 0,
                    1, 7, 3, 12'd4095, 0, 0));
    add_probe(probe(CMD_CLEAR, '1, '1, '1, '1, 1, 0, 0, 0, 0, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'd4095, 1, 0, 0, 12'd4095, 0, 0));
    add_probe(probe(CMD_INSERT, 0, 0, 0, 0, 1, 0, 0, 12'd0, 0, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'd0, 1, 0, 0, 12'd0, 0, 0));
    add_probe(probe(CMD_INSERT, 32'h1234_5678, 32'hFEDC_BA98, 32'h0003_4567,
                    12'hA5A, 0, 0, 0, 0, 0, 0));
    add_probe(probe(CMD_READ, 0, 0, 0, 12'h5A5, 0, 0, 0, 0, 0, 0));
    foreach (probe_tab[i]) send_request(probe_tab[i].req, probe_tab[i].typed, probe_tab[i].rsp);

    // Random phases, each with its own grid and one of three idling patterns
    for (int p = 0; p < 5; p++) begin
      drain_replies();
      case (p)
        0: load_grid(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        1: load_grid($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
        2: load_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1);
        3: load_grid($urandom, $urandom, $urandom, $urandom_range(1, 32'h0010_0000));
        default: load_grid($urandom, $urandom, $urandom,
                           32'h0001_0000 | (32'($urandom_range(1)) << 31));
      endcase
      if (p < 2) begin
        req_idle_pct = 20;
        rsp_idle_pct = 73;
      end else if (p < 4) begin
        req_idle_pct = 73;
        rsp_idle_pct = 20;
      end else begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_requests++;
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) send_request(random_request(), 1'b0, '0);
    end

    // Fresh grid: clear, four inserts, read back the last cell, clear again, one more insert
    drain_replies();
    load_grid(32'h0, 32'h0, 32'h0, $urandom);
    r = random_request();
    r.command = CMD_CLEAR;
    send_request(r, 1'b0, '0);
    repeat (4) begin
      r = random_request();
      r.command = CMD_INSERT;
      send_request(r, 1'b0, '0);
    end
    r.command    = CMD_READ;
    r.query_cell = last_cell;
    send_request(r, 1'b0, '0);
    r.command = CMD_CLEAR;
    send_request(r, 1'b0, '0);
    r.command = CMD_INSERT;
    send_request(r, 1'b0, '0);

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_replies == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
